// ===== design/mf3x3_pkg.sv =====
// Shared types, register indexes and median network stages for the 3x3 median filter.
`default_nettype none

package mf3x3_pkg;

  typedef logic [7:0] pix_t;
  typedef pix_t [8:0] win_t;

  typedef struct packed {
    logic [15:0] row;
    logic [11:0] col;
    logic        last_of_run;
    logic        frame_done;
  } meta_t;

  localparam logic [1:0] CFG_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_CHANNELS = 2'd2;

  localparam logic [10:0] WIDTH_RST    = 11'd1024;
  localparam logic [15:0] HEIGHT_RST   = 16'd1024;
  localparam logic [2:0]  CHANNELS_RST = 3'd1;
  localparam logic [2:0]  CH_MAX       = 3'd4;

  // window shift line: 2 * CH_MAX + 1 column triples
  localparam int WIN_TAPS = 9;
  localparam int TAP_W    = 4;

  // job phases, one bit each in the pending mask, issued lowest first
  localparam int PH_PREV_NORM  = 0;
  localparam int PH_PREV_FLUSH = 1;
  localparam int PH_LAST_NORM  = 2;
  localparam int PH_LAST_FLUSH = 3;

  function automatic win_t cx(input win_t v, input int lo, input int hi);
    win_t r;
    r = v;
    if (v[lo] > v[hi]) begin
      r[lo] = v[hi];
      r[hi] = v[lo];
    end
    return r;
  endfunction

  function automatic win_t med_s1(input win_t v);
    win_t r;
    r = v;
    r = cx(r, 1, 2); r = cx(r, 4, 5); r = cx(r, 7, 8);
    r = cx(r, 0, 1); r = cx(r, 3, 4); r = cx(r, 6, 7);
    r = cx(r, 1, 2); r = cx(r, 4, 5); r = cx(r, 7, 8);
    return r;
  endfunction

  function automatic win_t med_s2(input win_t v);
    win_t r;
    r = v;
    r = cx(r, 0, 3); r = cx(r, 5, 8); r = cx(r, 4, 7);
    r = cx(r, 3, 6); r = cx(r, 1, 4); r = cx(r, 2, 5);
    r = cx(r, 4, 7);
    return r;
  endfunction

  function automatic win_t med_s3(input win_t v);
    win_t r;
    r = v;
    r = cx(r, 4, 2); r = cx(r, 6, 4); r = cx(r, 4, 2);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/median_filter_3x3.sv =====
// 3x3 median filter over an interleaved 8-bit raster stream, three rotating line RAMs.
//
// Bytes enter on sample/in_valid/in_ready in raster order, channels interleaved.
// Results leave on out_valid/out_ready with median, row, byte column, last_of_run
// (last result caused by that byte) and frame_done (final byte of the frame).
// Registers are written on cfg_valid/cfg_ready (always ready), index on cfg_index:
// 0 image_width, 1 image_height, 2 channels. A write to index 0, 1 or 2 restarts the frame.
// Each byte reads its column from the two older line RAMs and is written into the
// third; the vertical triple enters a nine-deep window shift line and a job
// sequencer issues one median per cycle, unless the output stalls, into a three-stage
// sorting network. Throughput: one byte per cycle mid-row unless the output stalls;
// on the last row of a frame of two or more rows each byte issues two medians, and a
// row-end byte adds its flush medians, one per channel in each flush phase.
// The job sequencer, one median per cycle, sets the byte rate.
// Reset clears counters, pipeline valids and registers (1024 x 1024, one channel); line
// RAMs are not cleared. While out_valid is high and out_ready low the whole
// pipeline holds and in_ready is low.
`default_nettype none

module median_filter_3x3 #(
  parameter int MAX_LINE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       median,
  output logic [15:0]      out_row,
  output logic [11:0]      out_col,
  output logic             last_of_run,
  output logic             frame_done,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  import mf3x3_pkg::*;

  localparam int CW = $clog2(MAX_LINE_BYTES);
  localparam int LW = CW + 1;
  localparam int PW = 14;
  localparam int XW = (PW > LW) ? PW : LW;

  logic [10:0] image_width;
  logic [15:0] image_height;
  logic [2:0]  channels;

  logic [2:0]  ch_eff;
  logic [10:0] w_eff;
  logic [15:0] h_eff;
  logic [XW-1:0] prod;
  logic [LW-1:0] len;

  logic [CW-1:0] col_count;
  logic [15:0]   row_count;
  logic [1:0]    cur_sel;
  logic [CW-1:0] c_norm;
  logic [15:0]   r_norm;
  logic          rowend, last_row, cge;
  logic [1:0]    sel_a, sel_m, sel_next;

  logic accept, cfg_wr, en, load, issue;

  // column stage
  logic          v0;
  logic [7:0]    sample0;
  logic [CW-1:0] c0;
  logic [15:0]   r0;
  logic          prev0, r1_0, rz0, last0, end0, cge0;
  logic [1:0]    sel_a0, sel_m0;
  logic [7:0]    rd [3];

  // window and sequencer
  pix_t          wa [WIN_TAPS];
  pix_t          wm [WIN_TAPS];
  pix_t          ws [WIN_TAPS];
  logic [3:0]    pend;
  logic [1:0]    j;
  logic [CW-1:0] col_c;
  logic [15:0]   col_r;
  logic          f_r1, f_r0;

  logic          cur_prev, cur_flush, cur_lflush, last_job;
  logic [3:0]    pend_rest;
  logic [2:0]    off;
  logic [LW-1:0] x;
  logic [TAP_W-1:0] tl, tc, tr;
  win_t          wj_next;
  meta_t         mj_next;

  // median pipeline
  logic  jv, s1v, s2v;
  win_t  wj, w1, w2, w3;
  meta_t mj, m1, m2, mo;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;

  always_comb begin
    if (channels == 3'd0) begin
      ch_eff = 3'd1;
    end else if (channels > CH_MAX) begin
      ch_eff = CH_MAX;
    end else begin
      ch_eff = channels;
    end
    w_eff = (image_width == 11'd0) ? 11'd1 : image_width;
    h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
    prod  = XW'(w_eff) * XW'(ch_eff);
    len   = (prod > XW'(MAX_LINE_BYTES)) ? LW'(MAX_LINE_BYTES) : LW'(prod);

    c_norm   = (LW'(col_count) >= len) ? '0 : col_count;
    r_norm   = (row_count >= h_eff) ? 16'd0 : row_count;
    rowend   = (LW'(c_norm) == len - LW'(1));
    last_row = (r_norm >= h_eff - 16'd1);
    cge      = (LW'(c_norm) >= LW'(ch_eff));

    unique case (cur_sel)
      2'd0:    begin sel_m = 2'd2; sel_a = 2'd1; sel_next = 2'd1; end
      2'd1:    begin sel_m = 2'd0; sel_a = 2'd2; sel_next = 2'd2; end
      default: begin sel_m = 2'd1; sel_a = 2'd0; sel_next = 2'd0; end
    endcase
  end

  // sequencer: current phase is the lowest pending bit
  always_comb begin
    pend_rest  = pend & (pend - 4'd1);
    cur_prev   = pend[PH_PREV_NORM] | pend[PH_PREV_FLUSH];
    cur_flush  = !pend[PH_PREV_NORM] &&
                 (pend[PH_PREV_FLUSH] || (!pend[PH_LAST_NORM] && pend[PH_LAST_FLUSH]));
    cur_lflush = !pend[PH_PREV_NORM] && !pend[PH_PREV_FLUSH] && !pend[PH_LAST_NORM] &&
                 pend[PH_LAST_FLUSH];
    last_job   = (pend != 4'd0) && (pend_rest == 4'd0) && (!cur_flush || j == 2'd0);

    en       = !out_valid || out_ready;
    issue    = en && (pend != 4'd0);
    load     = en && v0 && (pend == 4'd0 || last_job);
    in_ready = en && (!v0 || load);
    accept   = in_valid && in_ready;

    off = cur_flush ? {1'b0, j} : ch_eff;
    x   = LW'(col_c) - LW'(off);
    tc  = TAP_W'(off);
    tl  = (x >= LW'(ch_eff)) ? TAP_W'(off) + TAP_W'(ch_eff) : TAP_W'(off);
    tr  = cur_flush ? TAP_W'(off) : '0;

    if (cur_prev) begin
      wj_next[0] = f_r1 ? wm[tl] : wa[tl];
      wj_next[1] = f_r1 ? wm[tc] : wa[tc];
      wj_next[2] = f_r1 ? wm[tr] : wa[tr];
      wj_next[3] = wm[tl];
      wj_next[4] = wm[tc];
      wj_next[5] = wm[tr];
    end else begin
      wj_next[0] = f_r0 ? ws[tl] : wm[tl];
      wj_next[1] = f_r0 ? ws[tc] : wm[tc];
      wj_next[2] = f_r0 ? ws[tr] : wm[tr];
      wj_next[3] = ws[tl];
      wj_next[4] = ws[tc];
      wj_next[5] = ws[tr];
    end
    wj_next[6] = ws[tl];
    wj_next[7] = ws[tc];
    wj_next[8] = ws[tr];

    mj_next.row         = cur_prev ? col_r - 16'd1 : col_r;
    mj_next.col         = 12'(x);
    mj_next.last_of_run = last_job;
    mj_next.frame_done  = cur_lflush && (j == 2'd0);
  end

  for (genvar g = 0; g < 3; g++) begin : g_line
    mf3x3_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LINE_BYTES)
    ) u_ram (
      .clk   (clk),
      .we    (accept && cur_sel == 2'(g)),
      .waddr (c_norm),
      .wdata (sample),
      .re    (accept),
      .raddr (c_norm),
      .rdata (rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      channels     <= CHANNELS_RST;
      col_count    <= '0;
      row_count    <= '0;
      cur_sel      <= 2'd0;
      v0           <= 1'b0;
      pend         <= 4'd0;
      j            <= 2'd0;
      jv           <= 1'b0;
      s1v          <= 1'b0;
      s2v          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr && cfg_index != 2'd3) begin
        unique case (cfg_index)
          CFG_WIDTH:  image_width  <= cfg_data[10:0];
          CFG_HEIGHT: image_height <= cfg_data;
          default:    channels     <= cfg_data[2:0];
        endcase
        col_count <= '0;
        row_count <= '0;
      end else if (accept) begin
        if (rowend) begin
          col_count <= '0;
          if (last_row) begin
            row_count <= '0;
          end else begin
            row_count <= r_norm + 16'd1;
            cur_sel   <= sel_next;
          end
        end else begin
          col_count <= c_norm + CW'(1);
        end
      end

      if (accept) begin
        v0 <= 1'b1;
      end else if (load) begin
        v0 <= 1'b0;
      end

      if (load) begin
        pend <= {last0 & end0, last0 & cge0, prev0 & end0, prev0 & cge0};
        j    <= 2'(ch_eff - 3'd1);
      end else if (issue) begin
        if (cur_flush && j != 2'd0) begin
          j <= j - 2'd1;
        end else begin
          pend <= pend_rest;
          j    <= 2'(ch_eff - 3'd1);
        end
      end

      if (en) begin
        jv        <= issue;
        s1v       <= jv;
        s2v       <= s1v;
        out_valid <= s2v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample0 <= sample;
      c0      <= c_norm;
      r0      <= r_norm;
      prev0   <= (r_norm != 16'd0);
      r1_0    <= (r_norm == 16'd1);
      rz0     <= (r_norm == 16'd0);
      last0   <= last_row;
      end0    <= rowend;
      cge0    <= cge;
      sel_a0  <= sel_a;
      sel_m0  <= sel_m;
    end
    if (load) begin
      wa[0] <= rd[sel_a0];
      wm[0] <= rd[sel_m0];
      ws[0] <= sample0;
      for (int i = 1; i < WIN_TAPS; i++) begin
        wa[i] <= wa[i-1];
        wm[i] <= wm[i-1];
        ws[i] <= ws[i-1];
      end
      col_c <= c0;
      col_r <= r0;
      f_r1  <= r1_0;
      f_r0  <= rz0;
    end
    if (en) begin
      wj <= wj_next;
      mj <= mj_next;
      w1 <= med_s1(wj);
      m1 <= mj;
      w2 <= med_s2(w1);
      m2 <= m1;
      w3 <= med_s3(w2);
      mo <= m2;
    end
  end

  assign median      = w3[4];
  assign out_row     = mo.row;
  assign out_col     = mo.col;
  assign last_of_run = mo.last_of_run;
  assign frame_done  = mo.frame_done;

`ifndef NO_ASSERTIONS
  a_sel_range: assert property (@(posedge clk) disable iff (rst) cur_sel != 2'd3)
    else $error("line RAM role pointer out of range");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!frame_done || last_of_run))
    else $error("frame_done without last_of_run");
  a_j_range: assert property (@(posedge clk) disable iff (rst)
    (pend != 4'd0) |-> (3'(j) < ch_eff))
    else $error("flush counter beyond channel count");
  a_col_loaded: assert property (@(posedge clk) disable iff (rst)
    accept |=> v0)
    else $error("accepted column lost before window load");
`endif

endmodule

`default_nettype wire

// ===== design/mf3x3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mf3x3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking 3x3 median filter testbench: frame table, receiver hold, random frames.
`default_nettype none

module tb;
  import mf3x3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  med;
    logic [15:0] row;
    logic [11:0] col;
    logic        lor;
    logic        fdone;
  } px_res_t;

  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [7:0]  sample;
  logic        out_valid, out_ready;
  logic [7:0]  median;
  logic [15:0] out_row;
  logic [11:0] out_col;
  logic        last_of_run, frame_done;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  median_filter_3x3 DUT (.*);

  // predictor state
  logic [7:0]  ln_up [4096];
  logic [7:0]  ln_mid [4096];
  logic [7:0]  ln_cur [4096];
  int unsigned rcnt, ccnt, wreg, hreg, chreg;
  px_res_t     pending_q[$];
  int          errors;
  int          send_idle, recv_idle;
  bit          hold_recv;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [7:0] med9(input logic [7:0] a [9]);
    logic [7:0] v [9];
    logic [7:0] t;
    int p [38];
    p = '{1,2,4,5,7,8,0,1,3,4,6,7,1,2,4,5,7,8,0,3,5,8,4,7,3,6,1,4,2,5,4,7,4,2,6,4,4,2};
    v = a;
    for (int i = 0; i < 19; i++)
      if (v[p[2*i]] > v[p[2*i+1]]) begin
        t = v[p[2*i]]; v[p[2*i]] = v[p[2*i+1]]; v[p[2*i+1]] = t;
      end
    return v[4];
  endfunction

  function automatic logic [7:0] win_med(input int sel_up, input int sel_mid,
                                         input int sel_dn, input int unsigned c,
                                         input int unsigned len, input int unsigned ch);
    logic [7:0] v [9];
    int unsigned cl, cr, cs [3];
    int sel [3];
    cl = (c >= ch) ? c - ch : c;
    cr = (c + ch < len) ? c + ch : c;
    cs = '{cl, c, cr};
    sel = '{sel_up, sel_mid, sel_dn};
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++)
        v[3*y+x] = (sel[y] == 0) ? ln_up[cs[x]] : (sel[y] == 1) ? ln_mid[cs[x]] : ln_cur[cs[x]];
    return med9(v);
  endfunction

  task automatic emit_row(input int su, input int sm, input int sd, input int unsigned row,
                          input int unsigned c, input int unsigned len,
                          input int unsigned ch, input int unsigned h);
    px_res_t e;
    int unsigned k;
    if (c >= ch) begin
      e.med = win_med(su, sm, sd, c - ch, len, ch);
      e.row = 16'(row); e.col = 12'(c - ch); e.lor = 1'b0; e.fdone = 1'b0;
      pending_q.push_back(e);
    end
    if (c == len - 1)
      for (k = (len > ch) ? len - ch : 0; k < len; k++) begin
        e.med = win_med(su, sm, sd, k, len, ch);
        e.row = 16'(row); e.col = 12'(k); e.lor = 1'b0;
        e.fdone = (row == h - 1 && k == len - 1);
        pending_q.push_back(e);
      end
  endtask

  task automatic predict_pixel(input logic [7:0] s);
    int unsigned ch, w, h, len, r, c, n0;
    bit lastr;
    ch = chreg == 0 ? 1 : (chreg > 4 ? 4 : chreg);
    w = wreg == 0 ? 1 : wreg;
    h = hreg == 0 ? 1 : hreg;
    len = w * ch;
    if (len > 4096) len = 4096;
    if (ccnt >= len) ccnt = 0;
    if (rcnt >= h) rcnt = 0;
    r = rcnt; c = ccnt;
    lastr = (r + 1 >= h);
    n0 = pending_q.size();
    ln_cur[c] = s;
    if (r >= 1) emit_row((r == 1) ? 1 : 0, 1, 2, r - 1, c, len, ch, h);
    if (lastr) emit_row((r == 0) ? 2 : 1, 2, 2, r, c, len, ch, h);
    if (pending_q.size() > n0) pending_q[$].lor = 1'b1;
    if (c == len - 1) begin
      ccnt = 0;
      if (lastr) rcnt = 0;
      else begin
        rcnt = r + 1;
        ln_up = ln_mid;
        ln_mid = ln_cur;
      end
    end else
      ccnt = c + 1;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIDTH:    wreg = 32'(d & 16'h7ff);
      CFG_HEIGHT:   hreg = 32'(d);
      CFG_CHANNELS: chreg = 32'(d & 16'h7);
      default: ;
    endcase
    rcnt = 0; ccnt = 0;
  endtask

  // in_valid stays high after a request; the caller lowers it at the end of a burst
  task automatic send_pixel(input logic [7:0] s);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; sample <= s;
    do @(posedge clk); while (!in_ready);
    predict_pixel(s);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while (pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk); guard++;
    end
    if (guard >= 200000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h, input int ch);
    drain();
    write_reg(CFG_WIDTH, 16'(w));
    write_reg(CFG_HEIGHT, 16'(h));
    write_reg(CFG_CHANNELS, 16'(ch));
    cfg_valid <= 0;
  endtask

  // receiver and checker
  initial begin
    px_res_t e;
    out_ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result exp none act %h/%0d/%0d", $time, median,
                   out_row, out_col);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if ({median, out_row, out_col, last_of_run, frame_done} !== e) begin
            $display("%0t: mismatch exp med %h row %0d col %0d lor %b fd %b", $time,
                     e.med, e.row, e.col, e.lor, e.fdone);
            $display("%0t:          act med %h row %0d col %0d lor %b fd %b", $time,
                     median, out_row, out_col, last_of_run, frame_done);
            errors++;
          end
        end
      end
      out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end
  end

  // directed table: width, height, channels, number of pixels, fixed value (-1 random)
  typedef struct { int w, h, ch, n, val; } step_t;
  step_t dir_tab [7] = '{
    '{1, 1, 1, 1, 255},
    '{1, 1, 0, 1, 0},
    '{0, 0, 7, 4, 170},
    '{3, 3, 1, 9, -1},
    '{2, 2, 3, 6, 85},
    '{1024, 1, 4, 0, -1},
    '{2, 3, 2, 0, -1}
  };

  initial begin
    px_res_t e;
    int w, h, ch, len, npix;
    rst = 1; in_valid = 0; sample = 0; cfg_valid = 0; cfg_index = CFG_WIDTH; cfg_data = 0;
    hold_recv = 0; errors = 0; send_idle = 31; recv_idle = 64;
    wreg = 32'(WIDTH_RST); hreg = 32'(HEIGHT_RST); chreg = 32'(CHANNELS_RST);
    rcnt = 0; ccnt = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // single pixel at reset width would need a full row; keep table short
    foreach (dir_tab[i]) begin
      set_frame(dir_tab[i].w, dir_tab[i].h, dir_tab[i].ch);
      for (int k = 0; k < dir_tab[i].n; k++)
        send_pixel(8'(dir_tab[i].val < 0 ? $urandom_range(255) : dir_tab[i].val));
      in_valid <= 0;
      if (i == 0) begin
        // one-pixel frame: median is the pixel itself
        e = '{8'd255, 16'd0, 12'd0, 1'b1, 1'b1};
        if (pending_q.size() != 1 || pending_q[0] !== e) begin
          $display("%0t: table row 0 exp %h act %h", $time, e, pending_q[0]);
          errors++;
        end
      end
    end
    // long receiver hold while sender keeps offering
    set_frame(6, 2, 1);
    fork
      begin
        hold_recv = 1;
        repeat (300) @(posedge clk);
        hold_recv = 0;
      end
      begin
        for (int k = 0; k < 12; k++) send_pixel(8'($urandom_range(255)));
        in_valid <= 0;
      end
    join
    drain();
    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 31 : (p == 1) ? 64 : 0;
      recv_idle = (p == 0) ? 64 : (p == 1) ? 31 : 0;
      npix = 0;
      while (npix < 30) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 5);
        h = $urandom_range(1, 4);
        ch = $urandom_range(0, 7);
        set_frame(w, h, ch);
        ch = ch == 0 ? 1 : (ch > 4 ? 4 : ch);
        len = w * ch;
        for (int k = 0; k < len * h; k++) begin
          send_pixel(($urandom_range(3) == 0) ?
                     (($urandom_range(1) != 0) ? 8'hff : 8'h00) : 8'($urandom_range(255)));
          npix++;
        end
        in_valid <= 0;
      end
    end
    // one wide row to reach upper width bits
    set_frame(1024, 1, 4);
    for (int k = 0; k < 6; k++) send_pixel(8'($urandom_range(255)));
    in_valid <= 0;
    drain();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

`default_nettype wire
